// ===== sv/rbd_pkg.sv =====
// shared types and constants of the ring buffer deque
`default_nettype none

package rbd_pkg;

   // storage size; one entry stays unused so that head equal to tail means empty
   localparam int DEPTH   = 1024;
   localparam int PTR_W   = $clog2(DEPTH);
   localparam int WORD_W  = 32;
   localparam int COUNT_W = 10;
   localparam int ACT_W   = 3;

   // action codes of a request word
   typedef enum logic [ACT_W-1:0] {
      ACT_NONE       = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_PUSH_FRONT = 3'd2,
      ACT_POP_FRONT  = 3'd3,
      ACT_POP_BACK   = 3'd4
   } action_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FETCH,
      ST_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic execute;
      logic load_fetch;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_fetch;
   } status_type;

   // next slot around the ring
   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   // previous slot around the ring
   function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == '0) begin
         r = PTR_W'(DEPTH - 1);
      end else begin
         r = p - PTR_W'(1);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/ring_buffer_deque.sv =====
// top level of the ring buffer deque
//
//   channel   direction  handshake             word
//   req_      in         req_valid/req_stall   action, value
//   rsp_      out        rsp_valid/rsp_stall   popped value and flag, count, empty,
//                                              front, back, push dropped
//
// An item goes from accept to result through capture, execute and respond, and
// a fetch too when a pop leaves items behind: the new front or back is read back
// from the single read port of the item store. One item is in flight at a time.
// Reset is synchronous and empties the deque at once; the store is not cleared.
// A stalled result holds, and no word is taken until it has gone.
`default_nettype none

module ring_buffer_deque
   import rbd_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic        [ACT_W-1:0]   req_action,
   input  wire logic signed [WORD_W-1:0]  req_value,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic signed      [WORD_W-1:0]  rsp_popped_value,
   output logic                           rsp_popped_ok,
   output logic             [COUNT_W-1:0] rsp_item_count,
   output logic                           rsp_is_empty,
   output logic signed      [WORD_W-1:0]  rsp_front_value,
   output logic signed      [WORD_W-1:0]  rsp_back_value,
   output logic                           rsp_push_dropped
);

   cmd_type    cmd;
   status_type status;

   // sequencing
   rbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // storage and result
   rbd_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_action       (req_action),
      .req_value        (req_value),
      .rsp_popped_value (rsp_popped_value),
      .rsp_popped_ok    (rsp_popped_ok),
      .rsp_item_count   (rsp_item_count),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_front_value  (rsp_front_value),
      .rsp_back_value   (rsp_back_value),
      .rsp_push_dropped (rsp_push_dropped)
   );

endmodule

`default_nettype wire

// ===== sv/rbd_ctrl.sv =====
// controller state machine of the ring buffer deque
`default_nettype none

module rbd_ctrl
   import rbd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.need_fetch) begin
               state_in = ST_FETCH;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_FETCH: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_stall      = 1'b1;
      rsp_valid      = 1'b0;
      cmd.capture    = 1'b0;
      cmd.execute    = 1'b0;
      cmd.load_fetch = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
         end
         ST_FETCH: begin
            cmd.load_fetch = 1'b1;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/rbd_datapath.sv =====
// pointers, item store and result registers of the ring buffer deque
`default_nettype none

module rbd_datapath
   import rbd_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire cmd_type                   cmd,
   output status_type                     status,
   input  wire logic        [ACT_W-1:0]   req_action,
   input  wire logic signed [WORD_W-1:0]  req_value,
   output logic signed      [WORD_W-1:0]  rsp_popped_value,
   output logic                           rsp_popped_ok,
   output logic             [COUNT_W-1:0] rsp_item_count,
   output logic                           rsp_is_empty,
   output logic signed      [WORD_W-1:0]  rsp_front_value,
   output logic signed      [WORD_W-1:0]  rsp_back_value,
   output logic                           rsp_push_dropped
);

   // captured request word
   logic [ACT_W-1:0]  action_ff;
   logic [WORD_W-1:0] value_ff;

   // ring state
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [PTR_W-1:0]  count_ff, count_in;
   logic [WORD_W-1:0] front_ff, front_in;
   logic [WORD_W-1:0] back_ff, back_in;

   // result registers
   logic [WORD_W-1:0] popped_ff, popped_in;
   logic              popped_ok_ff, popped_ok_in;
   logic              dropped_ff, dropped_in;
   logic              fetch_front_ff, fetch_front_in;

   // store ports
   logic [WORD_W-1:0] mem [DEPTH];
   logic              mem_we;
   logic [PTR_W-1:0]  mem_waddr;
   logic              mem_re;
   logic [PTR_W-1:0]  mem_raddr;
   logic [WORD_W-1:0] rd_data_ff;

   logic              empty;
   logic              full;
   logic              need_fetch;
   logic [31:0]       count_wide;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == PTR_W'(DEPTH - 1));

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_action;
         value_ff  <= req_value;
      end
   end

   // one action: pointer moves, store write, refill read
   always_comb begin
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      front_in       = front_ff;
      back_in        = back_ff;
      popped_in      = '0;
      popped_ok_in   = 1'b0;
      dropped_in     = 1'b0;
      fetch_front_in = fetch_front_ff;
      mem_we         = 1'b0;
      mem_waddr      = tail_ff;
      mem_re         = 1'b0;
      mem_raddr      = ptr_next(head_ff);
      need_fetch     = 1'b0;
      unique case (action_ff)
         ACT_PUSH_BACK: begin
            if (full) begin
               dropped_in = 1'b1;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = tail_ff;
               tail_in   = ptr_next(tail_ff);
               count_in  = count_ff + PTR_W'(1);
               back_in   = value_ff;
               if (empty) begin
                  front_in = value_ff;
               end
            end
         end
         ACT_PUSH_FRONT: begin
            if (full) begin
               dropped_in = 1'b1;
            end else begin
               head_in   = ptr_prev(head_ff);
               mem_we    = 1'b1;
               mem_waddr = ptr_prev(head_ff);
               count_in  = count_ff + PTR_W'(1);
               front_in  = value_ff;
               if (empty) begin
                  back_in = value_ff;
               end
            end
         end
         ACT_POP_FRONT: begin
            if (!empty) begin
               popped_in      = front_ff;
               popped_ok_in   = 1'b1;
               head_in        = ptr_next(head_ff);
               count_in       = count_ff - PTR_W'(1);
               mem_raddr      = ptr_next(head_ff);
               fetch_front_in = 1'b1;
               need_fetch     = (count_ff != PTR_W'(1));
            end
         end
         ACT_POP_BACK: begin
            if (!empty) begin
               popped_in      = back_ff;
               popped_ok_in   = 1'b1;
               tail_in        = ptr_prev(tail_ff);
               count_in       = count_ff - PTR_W'(1);
               mem_raddr      = ptr_prev(ptr_prev(tail_ff));
               fetch_front_in = 1'b0;
               need_fetch     = (count_ff != PTR_W'(1));
            end
         end
         default: begin
            popped_in = '0;
         end
      endcase
      mem_we = mem_we & cmd.execute;
      mem_re = need_fetch & cmd.execute;
   end

   assign status.need_fetch = need_fetch;

   // ring state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.execute) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         front_ff       <= front_in;
         back_ff        <= back_in;
         popped_ff      <= popped_in;
         popped_ok_ff   <= popped_ok_in;
         dropped_ff     <= dropped_in;
         fetch_front_ff <= fetch_front_in;
      end else if (cmd.load_fetch) begin
         if (fetch_front_ff) begin
            front_ff <= rd_data_ff;
         end else begin
            back_ff <= rd_data_ff;
         end
      end
   end

   // item store write port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= value_ff;
      end
   end

   // item store read port
   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   // result word
   assign count_wide       = 32'(count_ff);
   assign rsp_item_count   = count_wide[COUNT_W-1:0];
   assign rsp_is_empty     = empty;
   assign rsp_popped_value = popped_ff;
   assign rsp_popped_ok    = popped_ok_ff;
   assign rsp_push_dropped = dropped_ff;
   assign rsp_front_value  = empty ? '0 : front_ff;
   assign rsp_back_value   = empty ? '0 : back_ff;

endmodule

`default_nettype wire

// ===== sv/rbd_checker.sv =====
// port checks of the ring buffer deque and their binding
`default_nettype none

module rbd_checker
   import rbd_pkg::*;
(
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_stall,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_stall,
   input wire logic signed [WORD_W-1:0]  rsp_popped_value,
   input wire logic                      rsp_popped_ok,
   input wire logic        [COUNT_W-1:0] rsp_item_count,
   input wire logic                      rsp_is_empty,
   input wire logic signed [WORD_W-1:0]  rsp_front_value,
   input wire logic signed [WORD_W-1:0]  rsp_back_value,
   input wire logic                      rsp_push_dropped
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item_count)
         && $stable(rsp_popped_value) && $stable(rsp_front_value))
      else $error("stalled result word changed");

   // empty flag agrees with the count
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_item_count == '0)))
      else $error("empty flag and count disagree");

   // an empty deque shows zero at both ends
   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> rsp_front_value == '0 && rsp_back_value == '0)
      else $error("empty deque shows an item");

   // a failed or absent pop reports zero, and no word both pops and drops
   a_pop_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_popped_ok || rsp_popped_value == '0)
         && !(rsp_popped_ok && rsp_push_dropped))
      else $error("pop result flags inconsistent");

   // one word in flight: no request taken while a result is shown
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while result pending");

endmodule

bind ring_buffer_deque rbd_checker u_rbd_checker (.*);

`default_nettype wire

// ===== verif/tb.sv =====
// self-checking testbench of the ring buffer deque
module tb
   import rbd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES = 7;
   localparam int IDLE_PCT     = 12;
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_AT      = 400;
   localparam int QUIET_FROM   = 900;
   localparam int QUIET_TO     = 1200;
   localparam int STUCK_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 20;
   localparam int REPORT_MAX   = 10;
   localparam int CAPACITY     = DEPTH - 1;
   localparam logic [ACT_W-1:0] ACT_SPARE_LO = ACT_W'(ACT_POP_BACK) + 1'b1;
   localparam logic [ACT_W-1:0] ACT_SPARE_HI = '1;

   // one request word and the status word it should produce
   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [WORD_W-1:0] value;
   } deque_request_type;

   typedef struct packed {
      logic [WORD_W-1:0]  popped_value;
      logic               popped_ok;
      logic [COUNT_W-1:0] item_count;
      logic               is_empty;
      logic [WORD_W-1:0]  front_value;
      logic [WORD_W-1:0]  back_value;
      logic               push_dropped;
   } deque_status_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                      req_valid  = 1'b0;
   logic                      req_stall;
   logic        [ACT_W-1:0]   req_action = '0;
   logic signed [WORD_W-1:0]  req_value  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall  = 1'b0;
   logic signed [WORD_W-1:0]  rsp_popped_value;
   logic                      rsp_popped_ok;
   logic        [COUNT_W-1:0] rsp_item_count;
   logic                      rsp_is_empty;
   logic signed [WORD_W-1:0]  rsp_front_value;
   logic signed [WORD_W-1:0]  rsp_back_value;
   logic                      rsp_push_dropped;

   ring_buffer_deque dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_popped_value (rsp_popped_value),
      .rsp_popped_ok    (rsp_popped_ok),
      .rsp_item_count   (rsp_item_count),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_front_value  (rsp_front_value),
      .rsp_back_value   (rsp_back_value),
      .rsp_push_dropped (rsp_push_dropped)
   );

   always #2 clock = ~clock;

   deque_request_type pending_words[$];
   deque_status_type  expected_status[$];
   int gen_count     = 0;
   int sent_words    = 0;
   int checked_words = 0;
   int fail_count    = 0;
   int drops_seen    = 0;
   int empty_pops    = 0;
   int peak_count    = 0;
   int hold_left     = 0;
   logic hold_done   = 1'b0;
   int stuck_cycles  = 0;

   // predicted deque contents
   logic [WORD_W-1:0] model_mem [DEPTH];
   logic [PTR_W-1:0]  model_head = '0;
   logic [PTR_W-1:0]  model_tail = '0;

   function automatic logic [PTR_W-1:0] step_up(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] step_down(input logic [PTR_W-1:0] p);
      return (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
   endfunction

   function automatic int occupancy();
      return (int'(model_tail) + DEPTH - int'(model_head)) % DEPTH;
   endfunction

   // apply one action to the predicted deque and return the status it gives
   function automatic deque_status_type apply_action(input deque_request_type w);
      deque_status_type s;
      int held;
      s = '0;
      held = occupancy();
      unique case (w.action)
         ACT_PUSH_BACK: begin
            if (held >= CAPACITY) begin
               s.push_dropped = 1'b1;
            end else begin
               model_mem[model_tail] = w.value;
               model_tail = step_up(model_tail);
            end
         end
         ACT_PUSH_FRONT: begin
            if (held >= CAPACITY) begin
               s.push_dropped = 1'b1;
            end else begin
               model_head = step_down(model_head);
               model_mem[model_head] = w.value;
            end
         end
         ACT_POP_FRONT: begin
            if (held != 0) begin
               s.popped_value = model_mem[model_head];
               s.popped_ok = 1'b1;
               model_head = step_up(model_head);
            end
         end
         ACT_POP_BACK: begin
            if (held != 0) begin
               model_tail = step_down(model_tail);
               s.popped_value = model_mem[model_tail];
               s.popped_ok = 1'b1;
            end
         end
         default: begin
         end
      endcase
      held = occupancy();
      s.item_count = COUNT_W'(held);
      s.is_empty = (held == 0);
      if (held != 0) begin
         s.front_value = model_mem[model_head];
         s.back_value = model_mem[step_down(model_tail)];
      end
      return s;
   endfunction

   task automatic report(input string what, input logic [WORD_W-1:0] want,
                         input logic [WORD_W-1:0] got);
      fail_count++;
      if (fail_count <= REPORT_MAX) begin
         $display("tb: mismatch at %0t, %s: expected %h, got %h", $realtime, what, want, got);
      end
   endtask

   task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
      if (want !== got) begin
         report(name, want, got);
      end
   endtask

   // stimulus helpers; the generator tracks the fill level to steer phases
   task automatic queue_word(input logic [ACT_W-1:0] act, input logic [WORD_W-1:0] val);
      deque_request_type w;
      w = '{action: act, value: val};
      pending_words.insert(pending_words.size(), w);
      if ((act == ACT_PUSH_BACK || act == ACT_PUSH_FRONT) && gen_count < CAPACITY) begin
         gen_count++;
      end else if ((act == ACT_POP_FRONT || act == ACT_POP_BACK) && gen_count > 0) begin
         gen_count--;
      end
   endtask

   function automatic logic [ACT_W-1:0] pick_action(input int push_pct, input int pop_pct);
      int roll;
      roll = $urandom_range(99);
      if (roll < push_pct) begin
         return $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
      end else if (roll < push_pct + pop_pct) begin
         return $urandom_range(1) ? ACT_POP_FRONT : ACT_POP_BACK;
      end else if ($urandom_range(2) == 0) begin
         return ACT_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
      end
      return ACT_NONE;
   endfunction

   // request driver: hold a word until taken, then maybe idle
   always @(posedge clock) begin : drive_req
      deque_request_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_words.size() != 0 &&
             ((sent_words >= QUIET_FROM && sent_words < QUIET_TO) ||
              $urandom_range(99) >= IDLE_PCT)) begin
            w = pending_words[0];
            pending_words.delete(0);
            req_valid  <= 1'b1;
            req_action <= w.action;
            req_value  <= w.value;
            sent_words <= sent_words + 1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver: random stalls, one long hold-off, one calm stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && checked_words >= HOLD_AT) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (checked_words >= QUIET_FROM && checked_words < QUIET_TO) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < IDLE_PCT);
      end
   end

   // monitor: check taken results, then predict for taken requests
   always @(posedge clock) begin : watch
      deque_status_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            checked_words <= checked_words + 1;
            if (expected_status.size() == 0) begin
               report("result with none expected", '0, rsp_popped_value);
            end else begin
               want = expected_status[0];
               expected_status.delete(0);
               check_field("popped_value", want.popped_value, rsp_popped_value);
               check_field("popped_ok", WORD_W'(want.popped_ok), WORD_W'(rsp_popped_ok));
               check_field("item_count", WORD_W'(want.item_count), WORD_W'(rsp_item_count));
               check_field("is_empty", WORD_W'(want.is_empty), WORD_W'(rsp_is_empty));
               check_field("front_value", want.front_value, rsp_front_value);
               check_field("back_value", want.back_value, rsp_back_value);
               check_field("push_dropped", WORD_W'(want.push_dropped),
                           WORD_W'(rsp_push_dropped));
            end
         end
         if (req_valid && !req_stall) begin
            want = apply_action('{action: req_action, value: req_value});
            if (want.push_dropped) begin
               drops_seen++;
            end
            if ((req_action == ACT_POP_FRONT || req_action == ACT_POP_BACK) &&
                !want.popped_ok) begin
               empty_pops++;
            end
            if (int'(want.item_count) > peak_count) begin
               peak_count = int'(want.item_count);
            end
            expected_status.insert(expected_status.size(), want);
         end
      end
   end

   // watchdog on cycles where neither channel moves a word
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("tb: no progress for %0d cycles", STUCK_LIMIT);
         $display("tb: FAIL");
         $finish;
      end
   end

   initial begin
      // directed: empty pops, value extremes, wrap of head below zero, spare codes
      queue_word(ACT_POP_FRONT, $urandom);
      queue_word(ACT_POP_BACK, $urandom);
      queue_word(ACT_NONE, $urandom);
      queue_word(ACT_PUSH_BACK, 32'h7fff_ffff);
      queue_word(ACT_PUSH_FRONT, 32'h8000_0000);
      queue_word(ACT_PUSH_BACK, 32'h0000_0000);
      queue_word(ACT_PUSH_FRONT, 32'hffff_ffff);
      for (int c = ACT_SPARE_LO; c <= ACT_SPARE_HI; c++) begin
         queue_word(ACT_W'(c), $urandom);
      end
      queue_word(ACT_NONE, $urandom);
      queue_word(ACT_POP_BACK, $urandom);
      queue_word(ACT_POP_FRONT, $urandom);
      queue_word(ACT_POP_BACK, $urandom);
      queue_word(ACT_POP_FRONT, $urandom);
      queue_word(ACT_POP_BACK, $urandom);
      queue_word(ACT_PUSH_FRONT, 32'h5555_5555);
      queue_word(ACT_POP_BACK, $urandom);
      queue_word(ACT_PUSH_BACK, 32'haaaa_aaaa);
      queue_word(ACT_POP_FRONT, $urandom);
      queue_word(ACT_POP_FRONT, $urandom);

      // random mix around a shallow fill level
      repeat (260) begin
         queue_word(pick_action(40, 40), $urandom);
      end
      // fill to capacity, wrapping both pointers
      while (gen_count < CAPACITY) begin
         queue_word(pick_action(94, 3), $urandom);
      end
      // pushes against a full ring, with a pop and refill at the edge
      repeat (12) begin
         queue_word(pick_action(75, 0), $urandom);
      end
      queue_word(ACT_POP_FRONT, $urandom);
      queue_word(ACT_PUSH_FRONT, $urandom);
      queue_word(ACT_PUSH_BACK, $urandom);
      // drain mostly, with mixed traffic
      repeat (450) begin
         queue_word(pick_action(20, 70), $urandom);
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_valid || expected_status.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_status.size() != 0) begin
         report("results still missing", WORD_W'(expected_status.size()), '0);
      end

      $display("tb: %0d words checked, peak fill %0d of %0d", checked_words, peak_count,
               CAPACITY);
      $display("tb: %0d pushes refused when full, %0d pops on an empty deque", drops_seen,
               empty_pops);
      if (fail_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: %0d mismatches", fail_count);
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/rbd_pkg.sv
sv/rbd_ctrl.sv
sv/rbd_datapath.sv
sv/ring_buffer_deque.sv
sv/rbd_checker.sv
verif/tb.sv
